// File: rtl/core/box_filter_image_downsampler_assert.svh
`ifndef BOX_FILTER_IMAGE_DOWNSAMPLER_ASSERT_SVH
`define BOX_FILTER_IMAGE_DOWNSAMPLER_ASSERT_SVH

// Assertion helpers; every use samples on clk and is off while arst_n is low.
`ifndef ASSERT_OFF
`define BFD_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define BFD_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define BFD_ASSERT(lbl, prop, msg)
`define BFD_NEVER(lbl, cond, msg)
`endif

`endif

// File: rtl/core/bfd_pkg.sv
package bfd_pkg;

	// Width of the source dimension registers and of all position and boundary values.
	localparam int DIM_W = 13;
	localparam int TGT_W = 12;
	localparam int CNT_W = 5;
	localparam logic [CNT_W-1:0] CNT_MAX = 5'd31;

	// Configuration register indexes.
	localparam logic [1:0] CFG_SRC_W = 2'd0;
	localparam logic [1:0] CFG_SRC_H = 2'd1;
	localparam logic [1:0] CFG_TGT_W = 2'd2;
	localparam logic [1:0] CFG_TGT_H = 2'd3;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_UPD,
		ST_MUL,
		ST_EMIT
	} state_t;

	// Commands to a bin boundary stepper.
	typedef struct packed {
		logic start;
		logic load_first;
		logic advance;
	} bound_ctl_t;

endpackage

// File: rtl/core/bfd_ram.sv
module bfd_ram
	import bfd_pkg::*;
#(
	parameter int WIDTH = 85,
	parameter int DEPTH = 2048,
	parameter int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// One write port and one registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// File: rtl/core/bfd_bound.sv
module bfd_bound
	import bfd_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  bound_ctl_t       ctl,
	input  logic [DIM_W-1:0] src,
	input  logic [DIM_W-1:0] dst,
	output logic [DIM_W-1:0] bound,
	output logic             busy
);

	logic [DIM_W-1:0] dvd_q;
	logic [DIM_W-1:0] rem_q;
	logic [3:0]       iter_q;
	logic [DIM_W-1:0] bound_q;
	logic [DIM_W-1:0] acc_q;
	logic [DIM_W:0]   trial;
	logic             ge;
	logic [DIM_W-1:0] rem_next;
	logic [DIM_W-1:0] dvd_next;
	logic [DIM_W:0]   acc_sum;
	logic             acc_wrap;

	// One restoring division step per cycle: src = quotient * dst + remainder.
	always_comb begin
		trial    = {rem_q, dvd_q[DIM_W-1]};
		ge       = trial >= {1'b0, dst};
		rem_next = ge ? DIM_W'(trial - {1'b0, dst}) : trial[DIM_W-1:0];
		dvd_next = {dvd_q[DIM_W-2:0], ge};
		acc_sum  = {1'b0, acc_q} + {1'b0, rem_q};
		acc_wrap = acc_sum >= {1'b0, dst};
	end

	// After the division, dvd_q holds the quotient and rem_q the remainder.
	// Each advance moves the boundary by the quotient plus a carry from the
	// running fractional part.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q  <= '0;
			dvd_q   <= '0;
			rem_q   <= '0;
			bound_q <= '0;
			acc_q   <= '0;
		end else if (ctl.start) begin
			iter_q <= 4'(DIM_W);
			dvd_q  <= src;
			rem_q  <= '0;
		end else if (iter_q != '0) begin
			iter_q <= iter_q - 4'd1;
			dvd_q  <= dvd_next;
			rem_q  <= rem_next;
			if (iter_q == 4'd1) begin
				bound_q <= dvd_next;
				acc_q   <= rem_next;
			end
		end else if (ctl.load_first) begin
			bound_q <= dvd_q;
			acc_q   <= rem_q;
		end else if (ctl.advance) begin
			if (acc_wrap) begin
				acc_q   <= DIM_W'(acc_sum - {1'b0, dst});
				bound_q <= bound_q + dvd_q + DIM_W'(1);
			end else begin
				acc_q   <= acc_sum[DIM_W-1:0];
				bound_q <= bound_q + dvd_q;
			end
		end
	end

	assign bound = bound_q;
	assign busy  = iter_q != '0;

endmodule

// File: rtl/core/bfd_lane.sv
module bfd_lane
	import bfd_pkg::*;
#(
	parameter int CHANNEL_BITS = 16
) (
	input  logic                      clk,
	input  logic                      load,
	input  logic [CHANNEL_BITS+3:0]   sum,
	input  logic [CNT_W-1:0]          cnt,
	output logic [CHANNEL_BITS-1:0]   avg
);

	localparam int SUMW = CHANNEL_BITS + 4;
	localparam int SH   = SUMW + CNT_W;
	localparam int RW   = SH + 1;
	localparam int PW   = SUMW + RW;

	logic [RW-1:0]   recip_tab [32];
	logic [SUMW-1:0] sum_s1;
	logic [RW-1:0]   recip_s1;
	logic [PW-1:0]   prod_s2;
	logic [PW-SH-1:0] quot;

	// Rounded-up reciprocals of the pixel counts; an empty bin averages to zero.
	assign recip_tab[0] = '0;
	for (genvar Gi = 1; Gi < 32; Gi++) begin : g_recip
		assign recip_tab[Gi] = RW'(((64'd1 << SH) + 64'(Gi) - 64'd1) / Gi);
	end

	// Stage 1 holds the sum and reciprocal, stage 2 the product.
	always_ff @(posedge clk) begin
		if (load) begin
			sum_s1   <= sum;
			recip_s1 <= recip_tab[cnt];
		end
		prod_s2 <= PW'(sum_s1) * PW'(recip_s1);
	end

	// The shifted product is the exact truncated quotient; clip to full scale.
	always_comb begin
		quot = prod_s2[PW-1:SH];
		avg  = (|quot[PW-SH-1:CHANNEL_BITS]) ? '1 : quot[CHANNEL_BITS-1:0];
	end

endmodule

// File: rtl/core/box_filter_image_downsampler.sv
// Area-average image downsampler. Source RGBA pixels arrive in raster order,
// one transfer each; every destination pixel is the truncated mean of its
// source bin, with saturating sums and counts, and leaves as one transfer as
// soon as the bin's last source pixel is in. A pixel that completes no bin is
// accepted, then its column's accumulator in memory gets a read-modify-write;
// a pixel that completes a bin also passes through the two-stage reciprocal
// multiply in the four channel lanes and can be held by a stall on the output.
// After reset and after every register write the block holds in_stall high
// while it clears the column accumulators and divides out the bin sizes.
// Registers may be written only while the block is idle.
`include "box_filter_image_downsampler_assert.svh"

module box_filter_image_downsampler
	import bfd_pkg::*;
#(
	parameter int MAX_SRC_DIM   = 4096,
	parameter int MAX_DST_WIDTH = 2048,
	parameter int CHANNEL_BITS  = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [1:0]              cfg_index,
	input  logic [DIM_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [CHANNEL_BITS-1:0] in_red,
	input  logic [CHANNEL_BITS-1:0] in_green,
	input  logic [CHANNEL_BITS-1:0] in_blue,
	input  logic [CHANNEL_BITS-1:0] in_alpha,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic [CHANNEL_BITS-1:0] out_red,
	output logic [CHANNEL_BITS-1:0] out_green,
	output logic [CHANNEL_BITS-1:0] out_blue,
	output logic [CHANNEL_BITS-1:0] out_alpha,
	output logic [10:0]             out_col,
	output logic [10:0]             out_row,
	output logic                    frame_end
);

	localparam int SUMW    = CHANNEL_BITS + 4;
	localparam int WORDW   = 4 * SUMW + CNT_W;
	localparam int AW      = (MAX_DST_WIDTH > 1) ? $clog2(MAX_DST_WIDTH) : 1;
	localparam int SRC_CAP = (MAX_SRC_DIM > 8191) ? 8191 : MAX_SRC_DIM;
	localparam int DST_CAP = (MAX_DST_WIDTH > 4095) ? 4095 : MAX_DST_WIDTH;
	localparam logic [AW-1:0] LAST_ADDR = AW'(MAX_DST_WIDTH - 1);

	state_t state_q, state_d;

	logic [DIM_W-1:0] source_width_q, source_height_q;
	logic [TGT_W-1:0] target_width_q, target_height_q;
	logic             restart_q;
	logic [AW-1:0]    clr_addr_q;

	logic [DIM_W-1:0] sw_eff, sh_eff, dw_eff, dh_eff;
	logic [TGT_W-1:0] tw_clip, th_clip;

	logic [DIM_W-1:0] src_col_q, src_row_q, dst_col_q, dst_row_q;
	logic [DIM_W-1:0] col_bound, row_bound;
	logic             col_busy, row_busy;
	bound_ctl_t       col_ctl, row_ctl;

	logic [CHANNEL_BITS-1:0] pix_q [4];
	logic [SUMW-1:0]         new_sum [4];
	logic [CHANNEL_BITS-1:0] lane_avg [4];
	logic [SUMW:0]           raw_sum [4];
	logic [CNT_W-1:0]        new_cnt;

	logic             ram_we;
	logic [AW-1:0]    ram_waddr;
	logic [WORDW-1:0] ram_wdata, ram_rdata, new_word;

	logic col_last, row_last, line_last, frame_last, emit;
	logic col_more, row_more, accept, upd, out_free;

	logic [10:0]             meta_col_q, meta_row_q;
	logic                    meta_frame_q;
	logic                    out_valid_q;
	logic [CHANNEL_BITS-1:0] out_pix_q [4];
	logic [10:0]             out_col_q, out_row_q;
	logic                    frame_end_q;

	// Effective dimensions: zero counts as one, clip to the maximum, and never
	// let the target exceed the source.
	always_comb begin
		sw_eff = (source_width_q == '0) ? DIM_W'(1) :
			(source_width_q > DIM_W'(SRC_CAP)) ? DIM_W'(SRC_CAP) : source_width_q;
		sh_eff = (source_height_q == '0) ? DIM_W'(1) :
			(source_height_q > DIM_W'(SRC_CAP)) ? DIM_W'(SRC_CAP) : source_height_q;
		tw_clip = (target_width_q == '0) ? TGT_W'(1) :
			(target_width_q > TGT_W'(DST_CAP)) ? TGT_W'(DST_CAP) : target_width_q;
		th_clip = (target_height_q == '0) ? TGT_W'(1) :
			(target_height_q > TGT_W'(DST_CAP)) ? TGT_W'(DST_CAP) : target_height_q;
		dw_eff = ({1'b0, tw_clip} > sw_eff) ? sw_eff : {1'b0, tw_clip};
		dh_eff = ({1'b0, th_clip} > sh_eff) ? sh_eff : {1'b0, th_clip};
	end

	// Register writes store the value and schedule a restart of the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= DIM_W'(8);
			source_height_q <= DIM_W'(8);
			target_width_q  <= TGT_W'(4);
			target_height_q <= TGT_W'(4);
			restart_q       <= 1'b1;
		end else begin
			restart_q <= cfg_we;
			if (cfg_we) begin
				case (cfg_index)
					CFG_SRC_W: source_width_q  <= cfg_data;
					CFG_SRC_H: source_height_q <= cfg_data;
					CFG_TGT_W: target_width_q  <= cfg_data[TGT_W-1:0];
					CFG_TGT_H: target_height_q <= cfg_data[TGT_W-1:0];
					default:   restart_q <= 1'b0;
				endcase
			end
		end
	end

	// Bin and line position flags of the pixel being updated, and the handshake and state flags.
	always_comb begin
		col_last   = ({1'b0, src_col_q} + 14'd1) >= {1'b0, col_bound};
		row_last   = ({1'b0, src_row_q} + 14'd1) >= {1'b0, row_bound};
		line_last  = ({1'b0, src_col_q} + 14'd1) >= {1'b0, sw_eff};
		frame_last = line_last && (({1'b0, src_row_q} + 14'd1) >= {1'b0, sh_eff});
		emit       = col_last && row_last;
		col_more   = ({1'b0, dst_col_q} + 14'd1) < {1'b0, dw_eff};
		row_more   = ({1'b0, dst_row_q} + 14'd1) < {1'b0, dh_eff};
		accept     = (state_q == ST_IDLE) && !restart_q && in_valid;
		upd        = state_q == ST_UPD;
		out_free   = !out_valid_q || !out_stall;
	end

	// Boundary steppers for columns and rows.
	always_comb begin
		col_ctl.start      = restart_q;
		col_ctl.load_first = upd && line_last;
		col_ctl.advance    = upd && !line_last && col_last && col_more;
		row_ctl.start      = restart_q;
		row_ctl.load_first = upd && frame_last;
		row_ctl.advance    = upd && !frame_last && line_last && row_last && row_more;
	end

	bfd_bound u_col_bound (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (col_ctl),
		.src   (sw_eff),
		.dst   (dw_eff),
		.bound (col_bound),
		.busy  (col_busy)
	);

	bfd_bound u_row_bound (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (row_ctl),
		.src   (sh_eff),
		.dst   (dh_eff),
		.bound (row_bound),
		.busy  (row_busy)
	);

	// Saturating accumulation of the pixel into its column's word.
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			raw_sum[i] = {1'b0, ram_rdata[i*SUMW +: SUMW]} + (SUMW + 1)'(pix_q[i]);
			new_sum[i] = raw_sum[i][SUMW] ? '1 : raw_sum[i][SUMW-1:0];
		end
		new_cnt  = (ram_rdata[WORDW-1 -: CNT_W] == CNT_MAX) ? CNT_MAX :
			ram_rdata[WORDW-1 -: CNT_W] + CNT_W'(1);
		new_word = {new_cnt, new_sum[3], new_sum[2], new_sum[1], new_sum[0]};
	end

	// Memory port: the clearing sweep, or the write-back of an update.
	always_comb begin
		ram_we    = (state_q == ST_CLEAR) || upd;
		ram_waddr = (state_q == ST_CLEAR) ? clr_addr_q : dst_col_q[AW-1:0];
		ram_wdata = ((state_q == ST_CLEAR) || emit) ? '0 : new_word;
	end

	bfd_ram #(
		.WIDTH(WORDW),
		.DEPTH(MAX_DST_WIDTH),
		.AW   (AW)
	) u_acc_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(dst_col_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	// One lane per channel divides the bin sum by the pixel count.
	for (genvar Li = 0; Li < 4; Li++) begin : g_lane
		bfd_lane #(
			.CHANNEL_BITS(CHANNEL_BITS)
		) u_lane (
			.clk (clk),
			.load(upd && emit),
			.sum (new_sum[Li]),
			.cnt (new_cnt),
			.avg (lane_avg[Li])
		);
	end

	// Sequencer next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_ADDR && !col_busy && !row_busy) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_UPD;
				end
			end
			ST_UPD:  state_d = emit ? ST_MUL : ST_IDLE;
			ST_MUL:  state_d = ST_EMIT;
			ST_EMIT: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_CLEAR;
		endcase
		if (restart_q) begin
			state_d = ST_CLEAR;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (restart_q) begin
			clr_addr_q <= '0;
		end else if (state_q == ST_CLEAR && clr_addr_q != LAST_ADDR) begin
			clr_addr_q <= clr_addr_q + AW'(1);
		end
	end

	// Source and destination positions.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
		end else if (restart_q) begin
			src_col_q <= '0;
			src_row_q <= '0;
			dst_col_q <= '0;
			dst_row_q <= '0;
		end else if (upd) begin
			if (frame_last) begin
				src_col_q <= '0;
				src_row_q <= '0;
				dst_col_q <= '0;
				dst_row_q <= '0;
			end else if (line_last) begin
				src_col_q <= '0;
				dst_col_q <= '0;
				src_row_q <= src_row_q + DIM_W'(1);
				if (row_last && row_more) begin
					dst_row_q <= dst_row_q + DIM_W'(1);
				end
			end else begin
				src_col_q <= src_col_q + DIM_W'(1);
				if (col_last && col_more) begin
					dst_col_q <= dst_col_q + DIM_W'(1);
				end
			end
		end
	end

	// Input pixel and result position registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			pix_q[0] <= in_red;
			pix_q[1] <= in_green;
			pix_q[2] <= in_blue;
			pix_q[3] <= in_alpha;
		end
		if (upd) begin
			meta_col_q   <= dst_col_q[10:0];
			meta_row_q   <= dst_row_q[10:0];
			meta_frame_q <= frame_last;
		end
	end

	// Output register merges the lanes; the next pixel can be taken while it waits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			for (int i = 0; i < 4; i++) begin
				out_pix_q[i] <= lane_avg[i];
			end
			out_col_q   <= meta_col_q;
			out_row_q   <= meta_row_q;
			frame_end_q <= meta_frame_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE) || restart_q;
	assign out_valid = out_valid_q;
	assign out_red   = out_pix_q[0];
	assign out_green = out_pix_q[1];
	assign out_blue  = out_pix_q[2];
	assign out_alpha = out_pix_q[3];
	assign out_col   = out_col_q;
	assign out_row   = out_row_q;
	assign frame_end = frame_end_q;

	`BFD_ASSERT(a_upd_after_accept, state_q == ST_UPD |-> $past(state_q) == ST_IDLE,
		"update without an accepted pixel")
	`BFD_NEVER(a_accept_while_dividing, accept && (col_busy || row_busy),
		"pixel accepted before bin sizes are ready")
	`BFD_ASSERT(a_col_bound_range, state_q == ST_IDLE && !restart_q |-> col_bound <= sw_eff,
		"column boundary beyond the source width")
	`BFD_ASSERT(a_emit_lands, $past(state_q) == ST_EMIT && state_q == ST_IDLE |-> out_valid_q,
		"result left the sequencer without reaching the output")

endmodule

// File: tb/box_filter_image_downsampler_tb.sv
`timescale 1ns / 100ps

module box_filter_image_downsampler_tb;
	import bfd_pkg::*;

	localparam int MAX_SRC = 4096;
	localparam int MAX_DST = 2048;
	localparam int SUM_SAT = (1 << 20) - 1;
	localparam int CH_SAT = 65535;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SETTLE = 20;

	typedef struct {
		logic [15:0] red, green, blue, alpha;
		logic [10:0] col, row;
		logic        fend;
	} dst_pixel_t;

	typedef struct {
		logic [15:0] red, green, blue, alpha;
		bit          typed;
		dst_pixel_t  want;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              cfg_we = 1'b0;
	logic [1:0]        cfg_index = CFG_SRC_W;
	logic [DIM_W-1:0]  cfg_data = '0;
	logic              in_valid = 1'b0;
	logic              in_stall;
	logic [15:0]       in_red = '0, in_green = '0, in_blue = '0, in_alpha = '0;
	logic              out_valid;
	logic              out_stall = 1'b0;
	logic [15:0]       out_red, out_green, out_blue, out_alpha;
	logic [10:0]       out_col, out_row;
	logic              frame_end;

	// Side info travelling with the pixel on the input port.
	bit                cur_typed = 1'b0;
	dst_pixel_t        cur_want;

	bit                quiet = 1'b0;
	bit                press_req = 1'b0;
	bit                press_done = 1'b0;
	int                cycles = 0;
	int                mismatches = 0;
	dst_pixel_t        pending_pixels[$];
	dir_row_t          dir_tab[24];

	// Shadow of the block's registers and band accumulators.
	int                reg_sw, reg_sh, reg_tw, reg_th;
	int                acc_r[MAX_DST], acc_g[MAX_DST], acc_b[MAX_DST], acc_a[MAX_DST];
	int                acc_n[MAX_DST];
	int                scol, srow, dcol, drow, col_edge, row_edge;

	box_filter_image_downsampler dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_stall(in_stall),
		.in_red(in_red), .in_green(in_green), .in_blue(in_blue), .in_alpha(in_alpha),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_red(out_red), .out_green(out_green), .out_blue(out_blue),
		.out_alpha(out_alpha), .out_col(out_col), .out_row(out_row),
		.frame_end(frame_end)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("box_filter_image_downsampler_tb: errors");
			$finish;
		end
	end

	function automatic int dim_clamp(int v, int maxv);
		if (v == 0)
			return 1;
		return (v > maxv) ? maxv : v;
	endfunction

	function automatic int bound_at(int k, int src, int dst);
		longint p;
		p = longint'(k) * src;
		return int'(p / dst);
	endfunction

	function automatic int eff_sw();
		return dim_clamp(reg_sw, MAX_SRC);
	endfunction

	function automatic int eff_sh();
		return dim_clamp(reg_sh, MAX_SRC);
	endfunction

	function automatic int eff_dw();
		int d;
		d = dim_clamp(reg_tw, MAX_DST);
		return (d > eff_sw()) ? eff_sw() : d;
	endfunction

	function automatic int eff_dh();
		int d;
		d = dim_clamp(reg_th, MAX_DST);
		return (d > eff_sh()) ? eff_sh() : d;
	endfunction

	// Every register write starts a new frame with empty accumulators.
	function automatic void frame_restart();
		for (int i = 0; i < MAX_DST; i++) begin
			acc_r[i] = 0; acc_g[i] = 0; acc_b[i] = 0; acc_a[i] = 0; acc_n[i] = 0;
		end
		scol = 0; srow = 0; dcol = 0; drow = 0;
		col_edge = bound_at(1, eff_sw(), eff_dw());
		row_edge = bound_at(1, eff_sh(), eff_dh());
	endfunction

	function automatic int sat_sum(int a, int b);
		return (a + b > SUM_SAT) ? SUM_SAT : a + b;
	endfunction

	function automatic logic [15:0] mean_of(int s, int n);
		int q;
		if (n == 0)
			return '0;
		q = s / n;
		return (q > CH_SAT) ? 16'hFFFF : q[15:0];
	endfunction

	// Accumulates one source pixel and returns the finished destination pixel, if any.
	function automatic bit accumulate_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [15:0] a, output dst_pixel_t res);
		int  sw, sh, dw, dh, c;
		bit  col_last, row_last, line_last, frame_last, done;
		sw = eff_sw(); sh = eff_sh(); dw = eff_dw(); dh = eff_dh();
		c = dcol % MAX_DST;
		col_last = (scol + 1) >= col_edge;
		row_last = (srow + 1) >= row_edge;
		line_last = (scol + 1) >= sw;
		frame_last = line_last && ((srow + 1) >= sh);
		done = 1'b0;
		acc_r[c] = sat_sum(acc_r[c], r);
		acc_g[c] = sat_sum(acc_g[c], g);
		acc_b[c] = sat_sum(acc_b[c], b);
		acc_a[c] = sat_sum(acc_a[c], a);
		if (acc_n[c] < 31)
			acc_n[c]++;
		if (col_last && row_last) begin
			res.red = mean_of(acc_r[c], acc_n[c]);
			res.green = mean_of(acc_g[c], acc_n[c]);
			res.blue = mean_of(acc_b[c], acc_n[c]);
			res.alpha = mean_of(acc_a[c], acc_n[c]);
			res.col = dcol[10:0];
			res.row = drow[10:0];
			res.fend = frame_last;
			acc_r[c] = 0; acc_g[c] = 0; acc_b[c] = 0; acc_a[c] = 0; acc_n[c] = 0;
			done = 1'b1;
		end
		if (frame_last) begin
			scol = 0; srow = 0; dcol = 0; drow = 0;
			col_edge = bound_at(1, sw, dw);
			row_edge = bound_at(1, sh, dh);
		end else if (line_last) begin
			scol = 0;
			dcol = 0;
			col_edge = bound_at(1, sw, dw);
			if (row_last && drow + 1 < dh) begin
				drow++;
				row_edge = bound_at(drow + 1, sh, dh);
			end
			srow++;
		end else begin
			if (col_last && dcol + 1 < dw) begin
				dcol++;
				col_edge = bound_at(dcol + 1, sw, dw);
			end
			scol++;
		end
		return done;
	endfunction

	// Input transfers: predict, or take the typed value for directed rows.
	always @(negedge clk) begin
		dst_pixel_t res;
		if (arst_n && in_valid && !in_stall) begin
			if (accumulate_pixel(in_red, in_green, in_blue, in_alpha, res))
				pending_pixels.push_back(cur_typed ? cur_want : res);
		end
	end

	// Output transfers are checked against the oldest expectation.
	always @(negedge clk) begin
		dst_pixel_t w;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_pixels.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected output pixel col %0d row %0d", out_col, out_row);
			end else begin
				w = pending_pixels.pop_front();
				if (out_red !== w.red || out_green !== w.green || out_blue !== w.blue ||
						out_alpha !== w.alpha || out_col !== w.col || out_row !== w.row ||
						frame_end !== w.fend) begin
					mismatches++;
					if (mismatches <= 10)
						$display("pixel mismatch: want %h %h %h %h c%0d r%0d e%0d, got %h %h %h %h c%0d r%0d e%0d",
							w.red, w.green, w.blue, w.alpha, w.col, w.row, w.fend,
							out_red, out_green, out_blue, out_alpha, out_col, out_row,
							frame_end);
				end
			end
		end
	end

	// Output stall in random bursts, plus one long hold-off to back the block up.
	initial begin
		int n;
		forever begin
			@(posedge clk);
			if (press_req && !press_done) begin
				out_stall <= 1'b1;
				repeat (300) @(posedge clk);
				out_stall <= 1'b0;
				press_done <= 1'b1;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				n = $urandom_range(1, 15);
				out_stall <= ($urandom_range(0, 2) == 0);
				repeat (n - 1) @(posedge clk);
			end
		end
	end

	// One pixel transfer, held until accepted; a random input gap may follow.
	task automatic send_pixel(logic [15:0] r, logic [15:0] g, logic [15:0] b,
			logic [15:0] a, bit typed, dst_pixel_t want);
		in_valid <= 1'b1;
		in_red <= r; in_green <= g; in_blue <= b; in_alpha <= a;
		cur_typed <= typed;
		cur_want <= want;
		forever begin
			@(negedge clk);
			if (!in_stall)
				break;
		end
		@(posedge clk);
		if (!quiet && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic wait_idle();
		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_regs(int sw, int sh, int tw, int th);
		int vals[4];
		vals = '{sw, sh, tw, th};
		for (int i = 0; i < 4; i++) begin
			cfg_we <= 1'b1;
			cfg_index <= i[1:0];
			cfg_data <= vals[i][DIM_W-1:0];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
		reg_sw = sw & 'h1FFF;
		reg_sh = sh & 'h1FFF;
		reg_tw = tw & 'hFFF;
		reg_th = th & 'hFFF;
		frame_restart();
	endtask

	function automatic logic [15:0] rand_channel();
		case ($urandom_range(0, 7))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	task automatic run_phase(int sw, int sh, int tw, int th, int count);
		dst_pixel_t none;
		wait_idle();
		in_valid <= 1'b0;
		write_regs(sw, sh, tw, th);
		for (int i = 0; i < count; i++)
			send_pixel(rand_channel(), rand_channel(), rand_channel(), rand_channel(), 1'b0,
				none);
		in_valid <= 1'b0;
	endtask

	initial begin
		dst_pixel_t none;
		int sw;
		// Reset state: 8x8 source into 4x4, so bins are 2 by 2.
		reg_sw = 8; reg_sh = 8; reg_tw = 4; reg_th = 4;
		frame_restart();
		// Directed frame start: first band all white on top, half black below.
		for (int i = 0; i < 24; i++) begin
			dir_tab[i].typed = 1'b0;
			dir_tab[i].red = (i < 12) ? 16'hFFFF : 16'h0000;
			dir_tab[i].green = dir_tab[i].red;
			dir_tab[i].blue = dir_tab[i].red;
			dir_tab[i].alpha = dir_tab[i].red;
		end
		for (int i = 16; i < 24; i++) begin
			dir_tab[i].red = i[0] ? 16'hAAAA : 16'h5555;
			dir_tab[i].green = i[0] ? 16'h5555 : 16'hAAAA;
			dir_tab[i].blue = 16'h8001;
			dir_tab[i].alpha = 16'h7FFE;
		end
		for (int k = 0; k < 4; k++) begin
			dir_tab[9 + 2 * k].typed = 1'b1;
			dir_tab[9 + 2 * k].want = '{red: (k < 2) ? 16'hFFFF : 16'd32767,
				green: (k < 2) ? 16'hFFFF : 16'd32767, blue: (k < 2) ? 16'hFFFF : 16'd32767,
				alpha: (k < 2) ? 16'hFFFF : 16'd32767, col: k, row: 0, fend: 1'b0};
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (dir_tab[i])
			send_pixel(dir_tab[i].red, dir_tab[i].green, dir_tab[i].blue, dir_tab[i].alpha,
				dir_tab[i].typed, dir_tab[i].want);
		in_valid <= 1'b0;

		// Widest source and target (clamped), one-row frames.
		run_phase(8191, 1, 4095, 0, 60);
		// Bins far beyond the nominal scale: sums and counts saturate.
		run_phase(40, 2, 1, 1, 80);
		// Zero dimensions act as one: every pixel is a whole frame.
		run_phase(0, 0, 0, 0, 40);
		// Tallest source, one column.
		run_phase(1, 8191, 1, 4095, 60);
		// Uneven bins, with a long output hold-off once pixels are flowing.
		fork
			run_phase(7, 5, 3, 2, 140);
			begin
				@(posedge clk);
				wait (in_valid);
				repeat (20) @(posedge clk);
				press_req = 1'b1;
			end
		join
		for (int p = 0; p < 3; p++) begin
			sw = $urandom_range(1, 12);
			if (p == 2)
				quiet = 1'b1;
			run_phase(sw, $urandom_range(1, 6), $urandom_range(0, sw + 2),
				$urandom_range(0, 7), 40);
		end

		while (pending_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0)
			$display("box_filter_image_downsampler_tb: clean");
		else
			$display("box_filter_image_downsampler_tb: errors");
		$finish;
	end

endmodule
